// ===== rtl/sbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment branch playback sequencer package
// Shared widths, opcodes, register indexes and channel payload types.
// ----------------------------------------------------------------------------
package sbps_pkg;

   localparam int Segments      = 64;
   localparam int BranchesPerSeg = 4;
   localparam int FrameBits     = 24;
   localparam int SegBits       = 6;
   localparam int SlotBits      = 2;
   localparam int BrBits        = SegBits + SlotBits;
   localparam int CountBits     = 3;
   localparam int KeyBits       = 32;
   localparam int OffsetBits    = 27;
   localparam int PassBits      = 7;

   localparam logic [2:0] OpFetch   = 3'd0;
   localparam logic [2:0] OpLoadSeg = 3'd1;
   localparam logic [2:0] OpLoadBr  = 3'd2;
   localparam logic [2:0] OpSetTrig = 3'd3;
   localparam logic [2:0] OpJump    = 3'd4;

   localparam logic [0:0] RegSegCount  = 1'd0;
   localparam logic [0:0] RegBytesPerF = 1'd1;

   typedef struct packed {
      logic [2:0]           opcode;
      logic [SegBits-1:0]   seg_index;
      logic [SlotBits-1:0]  branch_slot;
      logic [FrameBits-1:0] frame_begin;
      logic [FrameBits-1:0] frame_end;
      logic [2:0]           branch_total;
      logic                 branch_cond;
      logic [KeyBits-1:0]   branch_key;
      logic [SegBits-1:0]   branch_dest;
      logic [KeyBits-1:0]   trigger_value;
   } req_type;

   typedef struct packed {
      logic                  frame_valid;
      logic [FrameBits-1:0]  frame_index;
      logic [OffsetBits-1:0] byte_offset;
      logic [SegBits-1:0]    current_segment;
      logic                  stopped;
   } rsp_type;

   typedef struct packed {
      logic       index;
      logic [6:0] data;
   } csr_type;

endpackage

// ===== rtl/sbps_chan_if.sv =====
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface sbps_req_if;
   import sbps_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sbps_rsp_if;
   import sbps_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sbps_csr_if;
   import sbps_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/segment_branch_playback_sequencer.sv =====
// ----------------------------------------------------------------------------
// Segment branch playback sequencer
// Steps through segment and branch tables one memory read at a time.
// ----------------------------------------------------------------------------
// Channel | Direction | Word
// req     | in        | opcode and operands
// rsp     | out       | frame index, byte offset, segment, stopped
// csr     | in        | register index and data
//
// Non-fetch words pass through accept, execute and response states. A fetch
// adds a segment read and check per segment visited, then at a segment end a
// branch read and check per branch tested and one more for the advance when no
// branch matches; an empty-segment run can visit 64 segments.
// Reset is synchronous and clears control state and the branch count valid bits.
// The response waits in its register until taken; no new word is accepted.
// ----------------------------------------------------------------------------
module segment_branch_playback_sequencer (
   input logic clock,
   input logic reset,
   sbps_req_if.sink   req,
   sbps_rsp_if.source rsp,
   sbps_csr_if.sink   csr
);
   import sbps_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EXEC = 7'b0000010,
      ST_SEGRD = 7'b0000100,
      ST_SEGCHK = 7'b0001000,
      ST_BRRD = 7'b0010000,
      ST_BRCHK = 7'b0100000,
      ST_OUT = 7'b1000000
   } state_type;

   // Tables.
   logic [FrameBits-1:0] seg_start_mem [Segments];
   logic [FrameBits-1:0] seg_stop_mem [Segments];
   logic [CountBits-1:0] br_count_mem [Segments];
   logic [KeyBits+SegBits:0] br_mem [Segments*BranchesPerSeg];
   logic [Segments-1:0] cnt_vld_ff; // branch count written since reset

   state_type state_ff;
   req_type req_ff;
   rsp_type rsp_ff;
   logic [SegBits-1:0] active_seg_ff;
   logic halted_ff;
   logic [FrameBits-1:0] pos_ff;
   logic [KeyBits-1:0] trig_ff;
   logic [6:0] seg_count_ff;
   logic [3:0] bpf_ff;
   logic [FrameBits-1:0] rd_start_ff, rd_stop_ff;
   logic [CountBits-1:0] rd_cnt_ff;
   logic rd_cnt_vld_ff;
   logic [KeyBits+SegBits:0] rd_br_ff;
   logic [SlotBits:0] slot_ff;
   logic [PassBits-1:0] pass_ff;
   logic is_end_ff; // leaving after a played frame

   logic [6:0] used;
   logic [FrameBits-1:0] seg_len;
   logic [SegBits:0] next_seg;
   logic [FrameBits-1:0] pos_inc;
   logic [FrameBits+3:0] prod;
   logic [CountBits-1:0] br_count;
   logic [CountBits-1:0] sat_total;

   always_comb begin
      used = seg_count_ff;
      if (used == 7'd0) used = 7'd1;
      if (used > 7'(Segments)) used = 7'(Segments);
      seg_len = (rd_stop_ff > rd_start_ff) ? rd_stop_ff - rd_start_ff : '0;
      next_seg = {1'b0, active_seg_ff} + 1'b1;
      pos_inc = pos_ff + 1'b1;
      prod = (FrameBits+4)'(rd_start_ff + pos_ff) * (FrameBits+4)'(bpf_ff);
      br_count = rd_cnt_vld_ff ? rd_cnt_ff : '0;
      sat_total = (req_ff.branch_total > 3'(BranchesPerSeg)) ?
         3'(BranchesPerSeg) : req_ff.branch_total;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.data = rsp_ff;

   // Table writes and registered reads.
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && req_ff.opcode == OpLoadSeg) begin
         seg_start_mem[req_ff.seg_index] <= req_ff.frame_begin;
         seg_stop_mem[req_ff.seg_index] <= req_ff.frame_end;
         br_count_mem[req_ff.seg_index] <= sat_total;
      end
      if (state_ff == ST_EXEC && req_ff.opcode == OpLoadBr)
         br_mem[{req_ff.seg_index, req_ff.branch_slot}] <=
            {req_ff.branch_cond, req_ff.branch_key, req_ff.branch_dest};
      rd_start_ff <= seg_start_mem[active_seg_ff];
      rd_stop_ff <= seg_stop_mem[active_seg_ff];
      rd_cnt_ff <= br_count_mem[active_seg_ff];
      rd_cnt_vld_ff <= cnt_vld_ff[active_seg_ff];
      rd_br_ff <= br_mem[{active_seg_ff, slot_ff[SlotBits-1:0]}];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_seg_ff <= '0;
         halted_ff <= 1'b0;
         pos_ff <= '0;
         trig_ff <= '0;
         seg_count_ff <= 7'd1;
         bpf_ff <= 4'd4;
         cnt_vld_ff <= '0;
      end else begin
         if (csr.valid) begin
            if (csr.data.index == RegSegCount) seg_count_ff <= csr.data.data;
            else bpf_ff <= csr.data.data[3:0];
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  req_ff <= req.data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               pass_ff <= '0;
               slot_ff <= '0;
               state_ff <= (req_ff.opcode == OpFetch && !halted_ff) ? ST_SEGRD : ST_OUT;
               case (req_ff.opcode)
                  OpLoadSeg: cnt_vld_ff[req_ff.seg_index] <= 1'b1;
                  OpSetTrig: trig_ff <= req_ff.trigger_value;
                  OpJump: begin
                     active_seg_ff <= req_ff.seg_index;
                     pos_ff <= '0;
                     halted_ff <= 1'b0;
                  end
                  default: ;
               endcase
               rsp_ff <= '{frame_valid: 1'b0, frame_index: '0, byte_offset: '0,
                           current_segment: (req_ff.opcode == OpJump) ?
                              req_ff.seg_index : active_seg_ff,
                           stopped: halted_ff && (req_ff.opcode != OpJump)};
            end
            ST_SEGRD: begin
               if ({1'b0, active_seg_ff} >= used) begin
                  halted_ff <= 1'b1;
                  rsp_ff.stopped <= 1'b1;
                  rsp_ff.current_segment <= active_seg_ff;
                  state_ff <= ST_OUT;
               end else state_ff <= ST_SEGCHK;
            end
            ST_SEGCHK: begin
               slot_ff <= '0;
               if (pos_ff < seg_len) begin
                  rsp_ff.frame_valid <= 1'b1;
                  rsp_ff.frame_index <= rd_start_ff + pos_ff;
                  rsp_ff.byte_offset <= prod[OffsetBits-1:0];
                  rsp_ff.current_segment <= active_seg_ff;
                  pos_ff <= pos_inc;
                  if (pos_inc >= seg_len) begin
                     is_end_ff <= 1'b1;
                     state_ff <= ST_BRRD;
                  end else state_ff <= ST_OUT;
               end else begin
                  is_end_ff <= 1'b0;
                  state_ff <= ST_BRRD;
               end
            end
            ST_BRRD: begin
               pos_ff <= '0;
               if (slot_ff < br_count)
                  state_ff <= ST_BRCHK;
               else begin
                  // No branch matched: advance with wrap.
                  active_seg_ff <= (next_seg >= used) ? '0 : next_seg[SegBits-1:0];
                  state_ff <= ST_BRCHK;
                  slot_ff <= 3'd7;
               end
            end
            ST_BRCHK: begin
               if (slot_ff != 3'd7 &&
                   (rd_br_ff[KeyBits+SegBits] !=
                    (rd_br_ff[KeyBits+SegBits-1:SegBits] == trig_ff))) begin
                  slot_ff <= slot_ff + 1'b1;
                  state_ff <= ST_BRRD;
               end else begin
                  if (slot_ff != 3'd7) begin
                     if ({1'b0, rd_br_ff[SegBits-1:0]} >= used) halted_ff <= 1'b1;
                     else active_seg_ff <= rd_br_ff[SegBits-1:0];
                  end
                  if (is_end_ff) begin
                     rsp_ff.stopped <= (slot_ff != 3'd7) &&
                        ({1'b0, rd_br_ff[SegBits-1:0]} >= used);
                     state_ff <= ST_OUT;
                  end else if (slot_ff != 3'd7 &&
                               {1'b0, rd_br_ff[SegBits-1:0]} >= used) begin
                     rsp_ff.stopped <= 1'b1;
                     rsp_ff.current_segment <= active_seg_ff;
                     state_ff <= ST_OUT;
                  end else if (pass_ff + 1'b1 >= 7'(Segments)) begin
                     halted_ff <= 1'b1;
                     rsp_ff.stopped <= 1'b1;
                     rsp_ff.current_segment <= (slot_ff != 3'd7) ?
                        rd_br_ff[SegBits-1:0] : active_seg_ff;
                     state_ff <= ST_OUT;
                  end else begin
                     pass_ff <= pass_ff + 1'b1;
                     state_ff <= ST_SEGRD;
                  end
               end
            end
            ST_OUT: begin
               if (rsp.ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== verif/sbps_tb_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel bundle note
// The channel interfaces come from the RTL; this file only fixes the time unit
// for the testbench compilation unit and holds a small shared type.
// ----------------------------------------------------------------------------
package sbps_tb_pkg;
   import sbps_pkg::*;

   // One expected response word.
   typedef struct packed {
      logic                  frame_valid;
      logic [FrameBits-1:0]  frame_index;
      logic [OffsetBits-1:0] byte_offset;
      logic [SegBits-1:0]    current_segment;
      logic                  stopped;
   } frame_expect_type;
endpackage

// ===== verif/segment_branch_playback_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment branch playback sequencer testbench
// Drives requests and register writes, predicts every response word from a
// behavioral copy of the segment and branch tables, and compares each word.
// ----------------------------------------------------------------------------
module segment_branch_playback_sequencer_tb;
   import sbps_pkg::*;
   import sbps_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbps_req_if req_ch ();
   sbps_rsp_if rsp_ch ();
   sbps_csr_if csr_ch ();

   segment_branch_playback_sequencer DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   always #4 clock = ~clock;

   // Predictor state.
   logic [FrameBits-1:0] seg_first [Segments];
   logic [FrameBits-1:0] seg_last  [Segments];
   logic [2:0]           seg_nbr   [Segments];
   logic                 br_eq_sel [Segments*BranchesPerSeg];
   logic [KeyBits-1:0]   br_match  [Segments*BranchesPerSeg];
   logic [SegBits-1:0]   br_goto   [Segments*BranchesPerSeg];
   int unsigned          play_seg;
   bit                   halted;
   int unsigned          play_pos;
   logic [KeyBits-1:0]   trig_word;
   int unsigned          seg_total;
   int unsigned          frame_bytes;

   frame_expect_type frames_due [$];
   int  errors = 0;
   int  cycles = 0;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_rsp;

   // Mismatch report.
   task automatic report(input string what, input int unsigned got, input int unsigned want);
      errors++;
      $display("tb: mismatch %s got %0h expected %0h at cycle %0d", what, got, want, cycles);
   endtask

   function automatic int unsigned live_count();
      live_count = (seg_total == 0) ? 1 : (seg_total > Segments ? Segments : seg_total);
   endfunction

   // Segment end: first matching branch wins, else move on with wrap.
   function automatic void close_segment();
      int unsigned s;
      int unsigned b;
      s = play_seg;
      play_pos = 0;
      for (int i = 0; i < seg_nbr[s]; i++) begin
         b = s * BranchesPerSeg + i;
         if (br_eq_sel[b] == (br_match[b] == trig_word)) begin
            if (br_goto[b] >= live_count()) halted = 1'b1;
            else play_seg = br_goto[b];
            return;
         end
      end
      play_seg = s + 1;
      if (play_seg >= live_count()) play_seg = 0;
   endfunction

   // Work out the response for one request and update the tables.
   function automatic frame_expect_type playback_step(input req_type r);
      frame_expect_type e;
      int unsigned passes;
      int unsigned len;
      int unsigned s;
      int unsigned b;
      logic [FrameBits-1:0] frame;
      bit got;
      got = 0;
      frame = '0;
      e = '0;
      case (r.opcode)
         OpFetch: begin
            passes = 0;
            while (!halted) begin
               s = play_seg;
               if (s >= live_count()) begin
                  halted = 1'b1;
                  break;
               end
               len = (seg_last[s] > seg_first[s]) ? seg_last[s] - seg_first[s] : 0;
               if (play_pos < len) begin
                  frame = seg_first[s] + play_pos;
                  got = 1;
                  e.current_segment = s;
                  play_pos = play_pos + 1;
                  if (play_pos >= len) close_segment();
                  break;
               end
               close_segment();
               passes++;
               if (passes >= Segments) begin
                  halted = 1'b1;
                  break;
               end
            end
         end
         OpLoadSeg: begin
            seg_first[r.seg_index] = r.frame_begin;
            seg_last[r.seg_index] = r.frame_end;
            seg_nbr[r.seg_index] = (r.branch_total > BranchesPerSeg) ? BranchesPerSeg
                                                                     : r.branch_total;
         end
         OpLoadBr: begin
            b = r.seg_index * BranchesPerSeg + r.branch_slot;
            br_eq_sel[b] = r.branch_cond;
            br_match[b] = r.branch_key;
            br_goto[b] = r.branch_dest;
         end
         OpSetTrig: trig_word = r.trigger_value;
         OpJump: begin
            play_seg = r.seg_index;
            play_pos = 0;
            halted = 1'b0;
         end
         default: ;
      endcase
      e.frame_valid = got;
      if (got) begin
         e.frame_index = frame;
         e.byte_offset = OffsetBits'(64'(frame) * frame_bytes);
      end else begin
         e.current_segment = play_seg;
      end
      e.stopped = halted;
      playback_step = e;
   endfunction

   // Cycle counter and limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 5000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Response side: random stall, and compare each accepted word.
   always @(posedge clock) begin
      frame_expect_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (frames_due.size() == 0) begin
            report("unexpected word", got.frame_index, 0);
         end else begin
            want = frames_due.pop_front();
            if (got.frame_valid !== want.frame_valid)
               report("frame_valid", got.frame_valid, want.frame_valid);
            if (got.frame_index !== want.frame_index)
               report("frame_index", got.frame_index, want.frame_index);
            if (got.byte_offset !== want.byte_offset)
               report("byte_offset", got.byte_offset, want.byte_offset);
            if (got.current_segment !== want.current_segment)
               report("current_segment", got.current_segment, want.current_segment);
            if (got.stopped !== want.stopped)
               report("stopped", got.stopped, want.stopped);
         end
      end
      rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Send one request word, predicting its response when accepted.
   // Valid stays high after acceptance; an idle gap, a register write or the end of the run drops it.
   task automatic send_word(input req_type r);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      frames_due.push_back(playback_step(r));
   endtask

   // Register write, only with the block idle.
   task automatic write_reg(input logic idx, input logic [6:0] val);
      req_ch.valid <= 1'b0;
      wait (frames_due.size() == 0);
      repeat (20) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= '{index: idx, data: val};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == RegSegCount) seg_total = val;
      else frame_bytes = val[3:0];
   endtask

   function automatic req_type blank_word();
      req_type r;
      r = $urandom;
      r.frame_begin = $urandom;
      r.frame_end = $urandom;
      r.branch_key = $urandom;
      r.trigger_value = $urandom;
      blank_word = r;
   endfunction

   task automatic load_segment(input int s, input int first, input int len, input int nbr);
      req_type r;
      r = blank_word();
      r.opcode = OpLoadSeg;
      r.seg_index = s;
      r.frame_begin = first;
      r.frame_end = first + len;
      r.branch_total = nbr;
      send_word(r);
   endtask

   task automatic load_branch(input int s, input int slot, input bit cnd,
                              input logic [31:0] key, input int dest);
      req_type r;
      r = blank_word();
      r.opcode = OpLoadBr;
      r.seg_index = s;
      r.branch_slot = slot;
      r.branch_cond = cnd;
      r.branch_key = key;
      r.branch_dest = dest;
      send_word(r);
   endtask

   task automatic simple_op(input logic [2:0] op, input int s, input logic [31:0] trig);
      req_type r;
      r = blank_word();
      r.opcode = op;
      r.seg_index = s;
      r.trigger_value = trig;
      send_word(r);
   endtask

   // Fill every branch slot of a segment so that any count reads written data.
   task automatic fill_branches(input int s);
      for (int k = 0; k < BranchesPerSeg; k++)
         load_branch(s, k, $urandom_range(1), $urandom_range(3), $urandom_range(70) % 64);
   endtask

   // Directed: extremes, every opcode, empty segments, bad targets, halts.
   task automatic test_directed();
      write_reg(RegSegCount, 7'd4);
      write_reg(RegBytesPerF, 7'd8);
      simple_op(OpJump, 0, 0);
      load_segment(0, 24'hFFFFFE, 2, 0);
      load_segment(1, 5, 0, 7);
      fill_branches(1);
      load_segment(2, 0, 1, 1);
      load_branch(2, 0, 1, 32'hFFFFFFFF, 63);
      load_segment(3, 100, 0, 0);
      simple_op(OpSetTrig, 0, 32'hFFFFFFFF);
      simple_op(OpJump, 0, 0);
      repeat (6) simple_op(OpFetch, 0, 0);
      simple_op(3'd7, 63, 0);
      simple_op(OpJump, 63, 0);
      simple_op(OpFetch, 0, 0);
      simple_op(OpJump, 1, 0);
      simple_op(OpFetch, 0, 0);
   endtask

   // Empty loop: all segments empty with no branches halts the fetch; then zero and oversized segment counts.
   task automatic test_empty_loop();
      write_reg(RegSegCount, 7'd64);
      write_reg(RegBytesPerF, 7'd1);
      for (int s = 0; s < Segments; s++) load_segment(s, 7, 0, 0);
      simple_op(OpJump, 5, 0);
      simple_op(OpFetch, 0, 0);
      simple_op(OpFetch, 0, 0);
      write_reg(RegSegCount, 7'd0);
      write_reg(RegBytesPerF, 7'd0);
      load_segment(0, 3, 2, 0);
      simple_op(OpJump, 0, 0);
      repeat (3) simple_op(OpFetch, 0, 0);
      write_reg(RegSegCount, 7'd127);
      simple_op(OpFetch, 0, 0);
   endtask

   // Random: short segments with branches, mostly fetches and triggers.
   task automatic test_random(input int words);
      int n;
      int pick;
      n = $urandom_range(2, 8);
      write_reg(RegSegCount, n);
      write_reg(RegBytesPerF, $urandom_range(1, 8));
      for (int s = 0; s < n; s++) begin
         load_segment(s, $urandom_range(1) ? $urandom : $urandom_range(20),
                      $urandom_range(3) == 0 ? 0 : $urandom_range(1, 4), $urandom_range(7));
         fill_branches(s);
      end
      simple_op(OpJump, 0, 0);
      for (int i = 0; i < words; i++) begin
         pick = $urandom_range(99);
         if (pick < 60) simple_op(OpFetch, $urandom, $urandom);
         else if (pick < 72) simple_op(OpSetTrig, 0, $urandom_range(4));
         else if (pick < 80) simple_op(OpJump, $urandom_range(n), 0);
         else if (pick < 86)
            load_segment($urandom_range(n - 1), $urandom, $urandom_range(4), $urandom_range(7));
         else if (pick < 93)
            load_branch($urandom_range(n - 1), $urandom_range(3), $urandom_range(1),
                        $urandom_range(1) ? $urandom : $urandom_range(4), $urandom);
         else simple_op($urandom_range(5, 7), $urandom, $urandom);
      end
   endtask

   // Long receiver hold-off while the sender keeps offering words.
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         test_random(40);
      join
   endtask

   initial begin
      for (int i = 0; i < Segments; i++) seg_nbr[i] = 0;
      play_seg = 0; halted = 0; play_pos = 0; trig_word = '0;
      seg_total = 1; frame_bytes = 4;
      hold_rsp = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_empty_loop();
      test_random(170);
      send_idle_pct = 54;
      test_random(170);
      send_idle_pct = 0; recv_stall_pct = 54;
      test_random(170);
      send_idle_pct = 36; recv_stall_pct = 36;
      test_random(170);
      send_idle_pct = 0; recv_stall_pct = 0;
      test_backpressure();
      req_ch.valid <= 1'b0;
      wait (frames_due.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
